FILE: sv/vmss_pkg.sv
// shared types and constants for the video mode sequencer with sprite scan
package vmss_pkg;

    localparam int DEF_SPRITE_SLOTS = 40;
    localparam int DEF_MAX_PER_LINE = 10;
    localparam int DEF_LINE_COUNTS  = 114;

    localparam int HBLANK_BASE  = 52;
    localparam int DRAW_BASE    = 43;
    localparam int VBLANK_LEN   = 1140;
    localparam int SEARCH_LEN   = 20;
    localparam int LAST_VISIBLE = 143;
    localparam int LAST_LINE    = 153;
    localparam int PROBE_OFS    = 16;
    localparam int TALL_HEIGHT  = 16;
    localparam int SHORT_HEIGHT = 8;

    localparam int CYCLE_W = 11;
    localparam int LINE_W  = 8;
    localparam int FOUND_W = 4;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_DRAW   = 2'd3
    } mode_t;

    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_SCAN = 1'b1
    } ctl_state_t;

    typedef struct packed {
        logic       kind;
        logic [5:0] sprite_slot;
        logic [7:0] sprite_y;
    } in_item_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] line;
        logic [3:0] sprites_found;
    } out_item_t;

    typedef struct packed {
        logic write_slot;
        logic tick;
        logic scan_start;
        logic scan_commit;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic scan_needed;
        logic scan_done;
        logic out_full;
    } dp_sts_t;

endpackage

FILE: sv/vmss_ctrl.sv
// control state machine: takes transactions and sequences the sprite scan
module vmss_ctrl
    import vmss_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_kind,
    output logic     s_ready,
    input  logic     m_ready,
    input  dp_sts_t  sts,
    output ctl_cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            CTL_IDLE: begin
                // output register is free or drains this cycle
                s_ready = !sts.out_full || m_ready;
                if (s_valid && s_ready) begin
                    if (s_kind == KIND_WRITE) begin
                        cmd.write_slot = 1'b1;
                        cmd.load_out   = 1'b1;
                    end else if (sts.scan_needed) begin
                        cmd.scan_start = 1'b1;
                        state_next     = CTL_SCAN;
                    end else begin
                        cmd.tick     = 1'b1;
                        cmd.load_out = 1'b1;
                    end
                end
            end
            CTL_SCAN: begin
                // finished count waits for a free output register
                if (sts.scan_done && (!sts.out_full || m_ready)) begin
                    cmd.scan_commit = 1'b1;
                    cmd.load_out    = 1'b1;
                    state_next      = CTL_IDLE;
                end
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/vmss_datapath.sv
// datapath: mode timing registers, sprite Y store, scan unit and output register
module vmss_datapath
    import vmss_pkg::*;
#(
    parameter int SPRITE_SLOTS = DEF_SPRITE_SLOTS,
    parameter int MAX_PER_LINE = DEF_MAX_PER_LINE,
    parameter int LINE_COUNTS  = DEF_LINE_COUNTS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  in_item_t  s_data,
    input  ctl_cmd_t  cmd,
    output dp_sts_t   sts,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int SLOT_AW = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;
    localparam int SCAN_CW = $clog2(SPRITE_SLOTS + 1);
    localparam int SUB_W   = $clog2(LINE_COUNTS);
    localparam logic [6:0]         SLOT_LIMIT = 7'(SPRITE_SLOTS);
    localparam logic [SCAN_CW-1:0] SCAN_END   = SCAN_CW'(SPRITE_SLOTS);
    localparam logic [SUB_W-1:0]   SUB_LAST   = SUB_W'(LINE_COUNTS - 1);
    localparam logic [FOUND_W-1:0] FOUND_CAP  = FOUND_W'(MAX_PER_LINE);

    logic                tall_sprites_reg;
    mode_t               mode_reg;
    logic [CYCLE_W-1:0]  cycle_count_reg;
    logic [SUB_W-1:0]    sub_count_reg;
    logic [LINE_W-1:0]   line_count_reg;
    logic [FOUND_W-1:0]  found_count_reg;

    mode_t               mode_next;
    logic [CYCLE_W-1:0]  cycle_count_next;
    logic [SUB_W-1:0]    sub_count_next;
    logic [LINE_W-1:0]   line_count_next;
    logic [FOUND_W-1:0]  found_count_next;

    // sprite Y store, entries read as zero until written
    logic [7:0]              y_mem [SPRITE_SLOTS];
    logic [SPRITE_SLOTS-1:0] slot_vld_reg;
    logic [7:0]              rd_y_reg;
    logic                    rd_entry_vld_reg;
    logic                    rd_vld_reg;

    logic                scan_active_reg;
    logic [SCAN_CW-1:0]  scan_idx_reg;
    logic [FOUND_W-1:0]  scan_cnt_reg;

    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic                step;
    logic                restart;
    logic [5:0]          n3;
    logic [5:0]          hb_lim;
    logic [6:0]          dr_lim;
    logic                wr_in_range;
    logic [SLOT_AW-1:0]  wr_idx;
    logic [SLOT_AW-1:0]  rd_idx;
    logic                issue;
    logic [8:0]          probe;
    logic [8:0]          top;
    logic [8:0]          height;
    logic                hit;

    assign wr_in_range = ({1'b0, s_data.sprite_slot} < SLOT_LIMIT);
    assign wr_idx      = s_data.sprite_slot[SLOT_AW-1:0];
    assign rd_idx      = scan_idx_reg[SLOT_AW-1:0];
    assign issue       = scan_active_reg && (scan_idx_reg != SCAN_END);

    // tick rules
    always_comb begin
        step             = cmd.tick || cmd.scan_commit;
        found_count_next = cmd.scan_commit ? scan_cnt_reg : found_count_reg;
        n3      = 6'({2'b00, found_count_reg} + {1'b0, found_count_reg, 1'b0});
        hb_lim  = 6'(HBLANK_BASE) - n3;
        dr_lim  = 7'(DRAW_BASE) + {1'b0, n3};
        restart         = 1'b0;
        mode_next       = mode_reg;
        line_count_next = line_count_reg;
        case (mode_reg)
            MODE_HBLANK: begin
                if (cycle_count_reg > {5'b0, hb_lim}) begin
                    mode_next = (line_count_reg < LINE_W'(LAST_VISIBLE)) ?
                                MODE_SEARCH : MODE_VBLANK;
                    line_count_next = line_count_reg + 1'b1;
                    restart   = 1'b1;
                end
            end
            MODE_VBLANK: begin
                if (cycle_count_reg > CYCLE_W'(VBLANK_LEN)) begin
                    mode_next       = MODE_SEARCH;
                    line_count_next = '0;
                    restart         = 1'b1;
                end else if (cycle_count_reg != '0 && sub_count_reg == '0 &&
                             line_count_reg < LINE_W'(LAST_LINE)) begin
                    line_count_next = line_count_reg + 1'b1;
                end
            end
            MODE_SEARCH: begin
                if (cycle_count_reg > CYCLE_W'(SEARCH_LEN)) begin
                    mode_next = MODE_DRAW;
                    restart   = 1'b1;
                end
            end
            MODE_DRAW: begin
                if (cycle_count_reg > {4'b0, dr_lim}) begin
                    mode_next = MODE_HBLANK;
                    restart   = 1'b1;
                end
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
        if (restart) begin
            cycle_count_next = '0;
            sub_count_next   = '0;
        end else begin
            cycle_count_next = cycle_count_reg + 1'b1;
            // sub count follows the counter modulo the line length
            sub_count_next   = (sub_count_reg == SUB_LAST) ? '0 : sub_count_reg + 1'b1;
        end
        if (!step) begin
            mode_next        = mode_reg;
            line_count_next  = line_count_reg;
            cycle_count_next = cycle_count_reg;
            sub_count_next   = sub_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tall_sprites_reg <= 1'b0;
            mode_reg         <= MODE_SEARCH;
            cycle_count_reg  <= '0;
            sub_count_reg    <= '0;
            line_count_reg   <= '0;
            found_count_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                tall_sprites_reg <= cfg_wr_data;
            end
            mode_reg        <= mode_next;
            cycle_count_reg <= cycle_count_next;
            sub_count_reg   <= sub_count_next;
            line_count_reg  <= line_count_next;
            found_count_reg <= found_count_next;
        end
    end

    // store write port and scan read port
    always_ff @(posedge aclk) begin
        if (cmd.write_slot && wr_in_range) begin
            y_mem[wr_idx] <= s_data.sprite_y;
        end
        if (issue) begin
            rd_y_reg <= y_mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_vld_reg <= '0;
        end else if (cmd.write_slot && wr_in_range) begin
            slot_vld_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_entry_vld_reg <= slot_vld_reg[rd_idx];
        end
    end

    // one slot per cycle, compare on the registered read
    assign probe  = {1'b0, line_count_reg} + 9'(PROBE_OFS);
    assign top    = rd_entry_vld_reg ? {1'b0, rd_y_reg} : 9'd0;
    assign height = tall_sprites_reg ? 9'(TALL_HEIGHT) : 9'(SHORT_HEIGHT);
    assign hit    = (probe >= top) && (probe < top + height);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_active_reg <= 1'b0;
            scan_idx_reg    <= '0;
            scan_cnt_reg    <= '0;
            rd_vld_reg      <= 1'b0;
        end else begin
            rd_vld_reg <= issue;
            if (cmd.scan_start) begin
                scan_active_reg <= 1'b1;
                scan_idx_reg    <= '0;
                scan_cnt_reg    <= '0;
            end else begin
                if (cmd.scan_commit) begin
                    scan_active_reg <= 1'b0;
                end
                if (issue) begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (rd_vld_reg && hit && scan_cnt_reg < FOUND_CAP) begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
            end
        end
    end

    assign sts.scan_needed = (mode_reg == MODE_SEARCH) && (cycle_count_reg == '0);
    assign sts.scan_done   = scan_active_reg && !issue && !rd_vld_reg;
    assign sts.out_full    = out_valid_reg;

    // output register parts the two channels
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg.mode          <= mode_next;
            out_data_reg.line          <= line_count_next;
            out_data_reg.sprites_found <= found_count_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTHESIS
    a_found_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        found_count_reg <= FOUND_CAP)
        else $error("sprite count above cap");

    a_line_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        line_count_reg <= LINE_W'(LAST_LINE))
        else $error("line counter out of range");

    a_commit_loads_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_commit |-> (!out_valid_reg || m_ready) && scan_active_reg)
        else $error("scan result would overwrite a pending transaction");
`endif

endmodule

FILE: sv/video_mode_sequencer_sprite_scan_core.sv
// Video mode sequencer with sprite Y scan: top level.
// Input channel s_valid/s_ready/s_data carries one transaction per item:
// kind 0 is one tick of video time, kind 1 writes a sprite Y position.
// Result channel m_valid/m_ready/m_data returns one transaction per input
// item with the mode, line and sprite count after that item, in order.
// cfg_wr_en/cfg_wr_data write the tall-sprite select, only while idle.
// Latency: a write or a plain tick gives its result one cycle after it is
// taken, and the next item may be taken in that cycle, so such items run at
// one per cycle. A tick that opens a sprite search scans the Y store one
// slot per cycle through its single read port: its result is loaded into the
// output register once the scan ends, and no item is taken meanwhile.
// A stalled receiver holds the result in the output register; the next item,
// or a finished search, moves on only in the cycle that register drains.
// Reset (aresetn low, synchronous) returns to sprite search at line 0 with
// all counts cleared; every sprite Y reads as zero until written, with no
// clearing pass.
module video_mode_sequencer_sprite_scan_core
    import vmss_pkg::*;
#(
    parameter int SPRITE_SLOTS = DEF_SPRITE_SLOTS,
    parameter int MAX_PER_LINE = DEF_MAX_PER_LINE,
    parameter int LINE_COUNTS  = DEF_LINE_COUNTS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    vmss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    vmss_datapath #(
        .SPRITE_SLOTS (SPRITE_SLOTS),
        .MAX_PER_LINE (MAX_PER_LINE),
        .LINE_COUNTS  (LINE_COUNTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

FILE: test/tb.sv
// testbench for the video mode sequencer sprite scan core
`timescale 1ns / 100ps

module tb;
    import vmss_pkg::*;

    localparam int SLOT_COUNT   = DEF_SPRITE_SLOTS;
    localparam int PER_LINE_CAP = DEF_MAX_PER_LINE;
    localparam int LINE_STEP    = DEF_LINE_COUNTS;
    localparam int DIR_ROWS     = 19;
    localparam int EXP_DEPTH    = 64;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t status;
    } vector_t;

    logic      aclk        = 1'b0;
    logic      aresetn     = 1'b0;
    logic      cfg_wr_en   = 1'b0;
    logic      cfg_wr_data = 1'b0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    in_item_t  s_data      = '0;
    logic      m_valid;
    logic      m_ready     = 1'b0;
    out_item_t m_data;

    // shadow copy of the sequencer state
    logic       model_tall;
    mode_t      model_mode;
    int         model_cycle;
    int         model_line;
    int         model_found;
    logic [7:0] sprite_tops [SLOT_COUNT];

    // ring of expected results, written on acceptance and read on output
    out_item_t expected_status [EXP_DEPTH];
    int        exp_wr_idx     = 0;
    int        exp_rd_idx     = 0;
    vector_t   directed_rows [DIR_ROWS];
    int        mismatch_count = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    bit        start_hold     = 1'b0;
    int        hold_left      = 0;

    video_mode_sequencer_sprite_scan_core uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always #2 aclk = ~aclk;

    task automatic flag_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic void scan_sprites();
        int height;
        int probe;
        int hits;
        height = model_tall ? TALL_HEIGHT : SHORT_HEIGHT;
        probe  = model_line + PROBE_OFS;
        hits   = 0;
        for (int s = 0; s < SLOT_COUNT && hits < PER_LINE_CAP; s++) begin
            if (probe >= int'(sprite_tops[s]) && probe < int'(sprite_tops[s]) + height) begin
                hits++;
            end
        end
        model_found = hits;
    endfunction

    function automatic void step_video_time();
        int n3;
        bit restart;
        n3      = model_found * 3;
        restart = 1'b0;
        case (model_mode)
            MODE_HBLANK: begin
                if (model_cycle > HBLANK_BASE - n3) begin
                    model_mode = (model_line < LAST_VISIBLE) ? MODE_SEARCH : MODE_VBLANK;
                    model_line = (model_line + 1) % 256;
                    restart    = 1'b1;
                end
            end
            MODE_VBLANK: begin
                if (model_cycle > VBLANK_LEN) begin
                    model_mode = MODE_SEARCH;
                    model_line = 0;
                    restart    = 1'b1;
                end else if (model_cycle != 0 && model_cycle % LINE_STEP == 0
                             && model_line < LAST_LINE) begin
                    model_line++;
                end
            end
            MODE_SEARCH: begin
                if (model_cycle > SEARCH_LEN) begin
                    model_mode = MODE_DRAW;
                    restart    = 1'b1;
                end else if (model_cycle == 0) begin
                    scan_sprites();
                end
            end
            default: begin
                if (model_cycle > DRAW_BASE + n3) begin
                    model_mode = MODE_HBLANK;
                    restart    = 1'b1;
                end
            end
        endcase
        model_cycle = restart ? 0 : (model_cycle + 1) % (1 << CYCLE_W);
    endfunction

    function automatic out_item_t video_status_after(input in_item_t it);
        out_item_t r;
        if (it.kind == KIND_WRITE) begin
            if (it.sprite_slot < SLOT_COUNT) begin
                sprite_tops[it.sprite_slot] = it.sprite_y;
            end
        end else begin
            step_video_time();
        end
        r.mode          = model_mode;
        r.line          = LINE_W'(model_line);
        r.sprites_found = FOUND_W'(model_found);
        return r;
    endfunction

    // writes mostly land near the line whose search comes next
    function automatic in_item_t random_item();
        in_item_t it;
        it.kind = ($urandom_range(99) < 30) ? KIND_WRITE : KIND_TICK;
        if ($urandom_range(9) == 0) begin
            it.sprite_slot = 6'($urandom_range(63));
        end else begin
            it.sprite_slot = 6'($urandom_range(SLOT_COUNT - 1));
        end
        if ($urandom_range(3) == 0) begin
            it.sprite_y = 8'($urandom);
        end else begin
            it.sprite_y = 8'(model_line + PROBE_OFS + 2 - int'($urandom_range(TALL_HEIGHT + 1)));
        end
        return it;
    endfunction

    // valid stays high into the next transaction unless a gap is taken
    task automatic offer_item(input in_item_t it, input logic typed = 1'b0,
                              input out_item_t typed_status = '0);
        out_item_t status;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        status = video_status_after(it);
        expected_status[exp_wr_idx % EXP_DEPTH] = typed ? typed_status : status;
        exp_wr_idx++;
    endtask

    task automatic run_items(input int count);
        repeat (count) offer_item(random_item());
        s_valid <= 1'b0;
    endtask

    task automatic write_tall(input logic value);
        while (exp_wr_idx != exp_rd_idx) @(posedge aclk);
        repeat (SLOT_COUNT + 4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        model_tall = value;
    endtask

    always @(posedge aclk) begin
        if (start_hold) begin
            hold_left  = 300;
            start_hold = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (exp_wr_idx == exp_rd_idx) begin
                flag_mismatch("status transaction with nothing pending");
            end else begin
                want = expected_status[exp_rd_idx % EXP_DEPTH];
                exp_rd_idx++;
                if (m_data.mode !== want.mode) begin
                    flag_mismatch($sformatf("mode %0d, want %0d", m_data.mode, want.mode));
                end
                if (m_data.line !== want.line) begin
                    flag_mismatch($sformatf("line %0d, want %0d", m_data.line, want.line));
                end
                if (m_data.sprites_found !== want.sprites_found) begin
                    flag_mismatch($sformatf("sprites_found %0d, want %0d",
                                            m_data.sprites_found, want.sprites_found));
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("[video_mode_sequencer_sprite_scan_core] ERROR");
        $finish;
    end

    initial begin : main_seq
        // twelve sprites on line 0 overflow the per-line cap
        directed_rows = '{
            '{'{KIND_WRITE, 6'd0,  8'd16},  1'b1, '{MODE_SEARCH, 8'd0, 4'd0}},
            '{'{KIND_WRITE, 6'd63, 8'd0},   1'b1, '{MODE_SEARCH, 8'd0, 4'd0}},
            '{'{KIND_WRITE, 6'd40, 8'd16},  1'b1, '{MODE_SEARCH, 8'd0, 4'd0}},
            '{'{KIND_WRITE, 6'd39, 8'd255}, 1'b0, '0},
            '{'{KIND_WRITE, 6'd1,  8'd16},  1'b0, '0},
            '{'{KIND_WRITE, 6'd2,  8'd16},  1'b0, '0},
            '{'{KIND_WRITE, 6'd3,  8'd16},  1'b0, '0},
            '{'{KIND_WRITE, 6'd4,  8'd16},  1'b0, '0},
            '{'{KIND_WRITE, 6'd5,  8'd16},  1'b0, '0},
            '{'{KIND_WRITE, 6'd6,  8'd16},  1'b0, '0},
            '{'{KIND_WRITE, 6'd7,  8'd16},  1'b0, '0},
            '{'{KIND_WRITE, 6'd8,  8'd16},  1'b0, '0},
            '{'{KIND_WRITE, 6'd9,  8'd16},  1'b0, '0},
            '{'{KIND_WRITE, 6'd10, 8'd16},  1'b0, '0},
            '{'{KIND_WRITE, 6'd11, 8'd16},  1'b0, '0},
            '{'{KIND_TICK,  6'd0,  8'd0},   1'b1, '{MODE_SEARCH, 8'd0, 4'd10}},
            '{'{KIND_TICK,  6'd63, 8'd255}, 1'b0, '0},
            '{'{KIND_WRITE, 6'd5,  8'd0},   1'b0, '0},
            '{'{KIND_TICK,  6'd21, 8'd170}, 1'b0, '0}
        };

        model_tall  = 1'b0;
        model_mode  = MODE_SEARCH;
        model_cycle = 0;
        model_line  = 0;
        model_found = 0;
        foreach (sprite_tops[i]) sprite_tops[i] = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        write_tall(1'b0);
        send_idle_pct  = 20;
        recv_stall_pct = 79;
        foreach (directed_rows[i]) begin
            offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].status);
        end
        s_valid <= 1'b0;
        run_items(530);

        write_tall(1'b1);
        send_idle_pct  = 79;
        recv_stall_pct = 20;
        start_hold     = 1'b1;
        run_items(530);

        write_tall(1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        start_hold     = 1'b1;
        run_items(540);

        while (exp_wr_idx != exp_rd_idx) @(posedge aclk);
        repeat (SLOT_COUNT + 8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[video_mode_sequencer_sprite_scan_core] OK");
        end else begin
            $display("[video_mode_sequencer_sprite_scan_core] ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/vmss_pkg.sv
sv/vmss_ctrl.sv
sv/vmss_datapath.sv
sv/video_mode_sequencer_sprite_scan_core.sv
test/tb.sv
